[hdl/hrrs_pkg.sv]
// Package: shared types and codes for the hash ring replica selector
package hrrs_pkg;
  typedef enum logic [1:0] {
    ACT_INSERT = 2'd0,
    ACT_LOOKUP = 2'd1,
    ACT_CLEAR  = 2'd2,
    ACT_NONE   = 2'd3
  } action_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_DUP   = 2'd2,
    ST_EMPTY = 2'd3
  } status_t;

  localparam int KEY_W = 64;
  localparam int COPIES_W = 5;
  localparam logic [COPIES_W-1:0] COPIES_RESET = 5'd3;
endpackage

[hdl/hrrs_ram.sv]
// Generic single-port-write, single-port-read RAM with registered read
module hrrs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

[hdl/hash_ring_replica_selector_unit.sv]
// Top level: consistent-hashing ring with sequenced insert and replica walk
//
// channel | signals                                     | handshake
// cmd     | start, action, key_value, host_id           | start & !busy
// cfg     | cfg_valid, cfg_data                         | cfg_valid & cfg_ready
// result  | result_valid, status, replica_token,        | strobe, one cycle
//         | replica_host, last                          |
//
// Insert: scan up to the insert point (SRD then SCMP per entry) then shift, with
// an MRD read and an MWR write per moved entry, set by the single memory read port.
// Lookup: scan to the start point, then per walked entry WRD, WCMP and CHK, plus a CHK
// step per chosen host compared; each replica goes out once the next choice or the end
// of the walk is known. Clear and an empty-ring lookup answer in the next cycle without
// going busy. Reset empties the ring; no clearing pass. Results cannot be stalled.
module hash_ring_replica_selector_unit #(
  parameter int RING_ENTRIES = 256,
  parameter int MAX_COPIES   = 16,
  parameter int HOST_BITS    = 8
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  action,
  input  logic [63:0] key_value,
  input  logic [7:0]  host_id,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [4:0]  cfg_data,
  output logic        result_valid,
  output logic [1:0]  status,
  output logic [63:0] replica_token,
  output logic [7:0]  replica_host,
  output logic        last
);
  localparam int AW = $clog2(RING_ENTRIES);
  localparam int CW = $clog2(RING_ENTRIES + 1);
  localparam int MW = (MAX_COPIES > 1) ? $clog2(MAX_COPIES) : 1;
  localparam int NW = $clog2(MAX_COPIES + 1);
  localparam int EW = hrrs_pkg::KEY_W + HOST_BITS;

  typedef enum logic [9:0] {
    S_IDLE  = 10'b0000000001,
    S_SRD   = 10'b0000000010,
    S_SCMP  = 10'b0000000100,
    S_MRD   = 10'b0000001000,
    S_MWR   = 10'b0000010000,
    S_WRNEW = 10'b0000100000,
    S_WRD   = 10'b0001000000,
    S_WCMP  = 10'b0010000000,
    S_CHK   = 10'b0100000000,
    S_FLUSH = 10'b1000000000
  } state_t;

  state_t state;
  logic [CW-1:0] ring_count;
  logic [4:0] copies_wanted;
  logic [1:0] act;
  logic [63:0] key;
  logic [HOST_BITS-1:0] host;
  logic [CW-1:0] idx;
  logic [AW-1:0] walk_begin, cur;
  logic [NW-1:0] chosen_count, emitted, want, chk;
  logic [HOST_BITS-1:0] chosen [MAX_COPIES];
  logic [63:0] cur_tok;
  logic [HOST_BITS-1:0] cur_host;
  logic [63:0] pend_tok;
  logic [HOST_BITS-1:0] pend_host;

  logic ram_we;
  logic [AW-1:0] ram_waddr, ram_raddr;
  logic [EW-1:0] ram_wdata, ram_rdata;
  logic [63:0] rd_tok;
  logic [HOST_BITS-1:0] rd_host;

  hrrs_ram #(.WIDTH(EW), .DEPTH(RING_ENTRIES)) u_ring (
    .clk(clk), .we(ram_we), .waddr(ram_waddr), .wdata(ram_wdata),
    .raddr(ram_raddr), .rdata(ram_rdata)
  );

  assign rd_tok  = ram_rdata[EW-1 -: 64];
  assign rd_host = ram_rdata[HOST_BITS-1:0];
  assign busy = (state != S_IDLE);
  assign cfg_ready = 1'b1;

  logic [AW-1:0] cur_inc;
  assign cur_inc = ({1'b0, cur} + CW'(1) >= ring_count) ? '0 : cur + AW'(1);

  always_comb begin
    ram_we = 1'b0;
    ram_waddr = idx[AW-1:0];
    ram_wdata = ram_rdata;
    ram_raddr = idx[AW-1:0];
    case (state)
      S_MRD: ram_raddr = AW'(idx - CW'(1));
      S_MWR: begin
        ram_we = 1'b1;
      end
      S_WRNEW: begin
        ram_we = 1'b1;
        ram_wdata = {key, host};
      end
      S_WRD: ram_raddr = cur;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      ring_count <= '0;
      copies_wanted <= hrrs_pkg::COPIES_RESET;
      result_valid <= 1'b0;
      emitted <= '0;
      want <= NW'(1);
    end else begin
      result_valid <= 1'b0;
      if (cfg_valid) copies_wanted <= cfg_data;
      case (state)
        S_IDLE: begin
          if (start) begin
            act <= action;
            key <= key_value;
            host <= HOST_BITS'(host_id);
            idx <= '0;
            chosen_count <= '0;
            emitted <= '0;
            if (copies_wanted > 5'(MAX_COPIES)) want <= NW'(MAX_COPIES);
            else if (copies_wanted == 5'd0) want <= NW'(1);
            else want <= NW'(copies_wanted);
            status <= hrrs_pkg::ST_OK;
            replica_token <= '0;
            replica_host <= '0;
            last <= 1'b1;
            case (hrrs_pkg::action_t'(action))
              hrrs_pkg::ACT_CLEAR: begin
                ring_count <= '0;
                result_valid <= 1'b1;
              end
              hrrs_pkg::ACT_LOOKUP: begin
                if (ring_count == '0) begin
                  status <= hrrs_pkg::ST_EMPTY;
                  result_valid <= 1'b1;
                end else state <= S_SRD;
              end
              hrrs_pkg::ACT_INSERT: state <= S_SRD;
              default: ;
            endcase
          end
        end
        S_SRD: begin
          if (idx == ring_count) begin
            if (act == hrrs_pkg::ACT_LOOKUP) begin
              walk_begin <= '0;
              cur <= '0;
              state <= S_WRD;
            end else if (ring_count == CW'(RING_ENTRIES)) begin
              status <= hrrs_pkg::ST_FULL;
              result_valid <= 1'b1;
              state <= S_IDLE;
            end else begin
              walk_begin <= idx[AW-1:0];
              idx <= ring_count;
              state <= S_MRD;
            end
          end else state <= S_SCMP;
        end
        S_SCMP: begin
          if (rd_tok >= key) begin
            if (act == hrrs_pkg::ACT_LOOKUP) begin
              walk_begin <= idx[AW-1:0];
              cur <= idx[AW-1:0];
              state <= S_WRD;
            end else if (rd_tok == key) begin
              status <= hrrs_pkg::ST_DUP;
              result_valid <= 1'b1;
              state <= S_IDLE;
            end else if (ring_count == CW'(RING_ENTRIES)) begin
              status <= hrrs_pkg::ST_FULL;
              result_valid <= 1'b1;
              state <= S_IDLE;
            end else begin
              walk_begin <= idx[AW-1:0];
              idx <= ring_count;
              state <= S_MRD;
            end
          end else begin
            idx <= idx + CW'(1);
            state <= S_SRD;
          end
        end
        S_MRD: begin
          if (idx[AW-1:0] == walk_begin && idx != CW'(RING_ENTRIES)) state <= S_WRNEW;
          else if (idx == {1'b0, walk_begin}) state <= S_WRNEW;
          else state <= S_MWR;
        end
        S_MWR: begin
          idx <= idx - CW'(1);
          state <= S_MRD;
        end
        S_WRNEW: begin
          ring_count <= ring_count + CW'(1);
          result_valid <= 1'b1;
          state <= S_IDLE;
        end
        S_WRD: state <= S_WCMP;
        S_WCMP: begin
          cur_tok <= rd_tok;
          cur_host <= rd_host;
          chk <= '0;
          state <= S_CHK;
        end
        S_CHK: begin
          if (chk != chosen_count && chosen[chk[MW-1:0]] == cur_host) begin
            cur <= cur_inc;
            if (cur_inc == walk_begin) begin
              result_valid <= 1'b1;
              replica_token <= pend_tok;
              replica_host <= 8'(pend_host);
              last <= 1'b1;
              state <= S_IDLE;
            end else state <= S_WRD;
          end else if (chk != chosen_count) begin
            chk <= chk + NW'(1);
          end else begin
            chosen[chosen_count[MW-1:0]] <= cur_host;
            chosen_count <= chosen_count + NW'(1);
            emitted <= emitted + NW'(1);
            if (emitted != '0) begin
              result_valid <= 1'b1;
              replica_token <= pend_tok;
              replica_host <= 8'(pend_host);
              last <= 1'b0;
            end
            pend_tok <= cur_tok;
            pend_host <= cur_host;
            cur <= cur_inc;
            if ((emitted + NW'(1) >= want) || (cur_inc == walk_begin)) state <= S_FLUSH;
            else state <= S_WRD;
          end
        end
        S_FLUSH: begin
          result_valid <= 1'b1;
          replica_token <= pend_tok;
          replica_host <= 8'(pend_host);
          last <= 1'b1;
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    ring_count <= CW'(RING_ENTRIES)) else $error("ring count overflow");
  a_emit_bound: assert property (@(posedge clk) disable iff (rst)
    emitted <= want) else $error("too many replicas");
  a_res_idle: assert property (@(posedge clk) disable iff (rst)
    result_valid && last |-> state == S_IDLE) else $error("last while busy");
endmodule

[tb/sv/tb_top.sv]
// Testbench for hash_ring_replica_selector_unit: directed and random traffic
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int RING_MAX    = 256;
  localparam int COPIES_MAX  = 16;
  localparam int SETTLE      = 40;
  localparam int STALL_LIMIT = 60000;

  typedef struct {
    hrrs_pkg::status_t st;
    logic [63:0]       token;
    logic [7:0]        host;
    logic              fin;
  } replica_t;

  logic        clk = 0;
  logic        rst = 1;
  logic        start = 0;
  logic        busy;
  logic [1:0]  action = 0;
  logic [63:0] key_value = 0;
  logic [7:0]  host_id = 0;
  logic        cfg_valid = 0;
  logic        cfg_ready;
  logic [4:0]  cfg_data = 0;
  logic        result_valid;
  logic [1:0]  status;
  logic [63:0] replica_token;
  logic [7:0]  replica_host;
  logic        last;

  hash_ring_replica_selector_unit dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .action(action),
    .key_value(key_value), .host_id(host_id), .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready), .cfg_data(cfg_data), .result_valid(result_valid),
    .status(status), .replica_token(replica_token), .replica_host(replica_host),
    .last(last)
  );

  always #10 clk = ~clk;

  // ring model
  logic [63:0] ring_tok[$];
  logic [7:0]  ring_host[$];
  logic [4:0]  copies_reg = hrrs_pkg::COPIES_RESET;
  replica_t    replicas_due[$];
  int          mismatches = 0;
  int          stall_cycles = 0;
  bit          gaps_on = 1;

  function automatic void push_replica(hrrs_pkg::status_t st, logic [63:0] t, logic [7:0] h,
                                       logic f);
    replica_t r;
    r.st = st; r.token = t; r.host = h; r.fin = f;
    replicas_due.push_back(r);
  endfunction

  function automatic void predict_replicas(hrrs_pkg::action_t a, logic [63:0] k,
                                           logic [7:0] h);
    int pos, beg, cur, n, want;
    logic [7:0] picked[$];
    bit seen;
    case (a)
      hrrs_pkg::ACT_INSERT: begin
        pos = 0;
        while (pos < ring_tok.size() && ring_tok[pos] < k) pos++;
        if (pos < ring_tok.size() && ring_tok[pos] == k)
          push_replica(hrrs_pkg::ST_DUP, 0, 0, 1);
        else if (ring_tok.size() >= RING_MAX) push_replica(hrrs_pkg::ST_FULL, 0, 0, 1);
        else begin
          ring_tok.insert(pos, k);
          ring_host.insert(pos, h);
          push_replica(hrrs_pkg::ST_OK, 0, 0, 1);
        end
      end
      hrrs_pkg::ACT_CLEAR: begin
        ring_tok.delete();
        ring_host.delete();
        push_replica(hrrs_pkg::ST_OK, 0, 0, 1);
      end
      hrrs_pkg::ACT_LOOKUP: begin
        if (ring_tok.size() == 0) push_replica(hrrs_pkg::ST_EMPTY, 0, 0, 1);
        else begin
          want = (copies_reg > COPIES_MAX) ? COPIES_MAX : copies_reg;
          beg = 0;
          for (int i = ring_tok.size() - 1; i >= 0; i--)
            if (ring_tok[i] >= k) beg = i;
          cur = beg;
          n = 0;
          do begin
            seen = 0;
            foreach (picked[j]) if (picked[j] == ring_host[cur]) seen = 1;
            if (!seen && picked.size() < COPIES_MAX) begin
              picked.push_back(ring_host[cur]);
              push_replica(hrrs_pkg::ST_OK, ring_tok[cur], ring_host[cur], 0);
              n++;
            end
            cur++;
            if (cur >= ring_tok.size()) cur = 0;
          end while (n < want && cur != beg);
          replicas_due[replicas_due.size() - 1].fin = 1;
        end
      end
      default: ;
    endcase
  endfunction

  always @(posedge clk) begin
    replica_t exp_r;
    if (!rst && result_valid) begin
      if (replicas_due.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result: st=%0d tok=%h host=%h last=%b",
                   status, replica_token, replica_host, last);
      end else begin
        exp_r = replicas_due.pop_front();
        if (status !== exp_r.st || replica_token !== exp_r.token ||
            replica_host !== exp_r.host || last !== exp_r.fin) begin
          mismatches++;
          if (mismatches <= 10)
            $display({"mismatch: exp st=%0d tok=%h host=%h last=%b",
                      " got st=%0d tok=%h host=%h last=%b"},
                     exp_r.st, exp_r.token, exp_r.host, exp_r.fin,
                     status, replica_token, replica_host, last);
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((start && !busy) || result_valid || (cfg_valid && cfg_ready)) stall_cycles <= 0;
    else stall_cycles <= stall_cycles + 1;
    if (stall_cycles >= STALL_LIMIT) begin
      $display("hash_ring_replica_selector_unit verification failed");
      $finish;
    end
  end

  // called at a falling edge; leaves start high at a falling edge
  task automatic send_cmd(hrrs_pkg::action_t a, logic [63:0] k, logic [7:0] h);
    if (gaps_on && $urandom_range(0, 3) == 0) begin
      start <= 0;
      repeat ($urandom_range(1, 12)) @(negedge clk);
    end
    start <= 1;
    action <= a;
    key_value <= k;
    host_id <= h;
    @(posedge clk);
    while (busy) @(posedge clk);
    predict_replicas(a, k, h);
    @(negedge clk);
  endtask

  task automatic drain;
    start <= 0;
    while (replicas_due.size() != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
  endtask

  task automatic write_copies(logic [4:0] v);
    cfg_valid <= 1;
    cfg_data <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    copies_reg = v;
    @(negedge clk);
    cfg_valid <= 0;
  endtask

  function automatic logic [63:0] rand_key();
    return {$urandom, $urandom};
  endfunction

  task automatic test_directed;
    send_cmd(hrrs_pkg::ACT_LOOKUP, 64'h0, 8'h00);
    send_cmd(hrrs_pkg::ACT_INSERT, 64'h0, 8'h00);
    send_cmd(hrrs_pkg::ACT_INSERT, 64'hFFFF_FFFF_FFFF_FFFF, 8'hFF);
    send_cmd(hrrs_pkg::ACT_INSERT, 64'h8000_0000_0000_0000, 8'h5A);
    send_cmd(hrrs_pkg::ACT_INSERT, 64'h4000_0000_0000_0000, 8'hA5);
    send_cmd(hrrs_pkg::ACT_INSERT, 64'h9000_0000_0000_0000, 8'h5A);
    send_cmd(hrrs_pkg::ACT_INSERT, 64'h8000_0000_0000_0000, 8'h11);
    send_cmd(hrrs_pkg::ACT_LOOKUP, 64'h0, 8'hFF);
    send_cmd(hrrs_pkg::ACT_LOOKUP, 64'hFFFF_FFFF_FFFF_FFFF, 8'h00);
    send_cmd(hrrs_pkg::ACT_LOOKUP, 64'h7FFF_FFFF_FFFF_FFFF, 8'h00);
    send_cmd(hrrs_pkg::ACT_LOOKUP, 64'h8000_0000_0000_0001, 8'h00);
    send_cmd(hrrs_pkg::ACT_NONE, 64'hFFFF_FFFF_FFFF_FFFF, 8'hFF);
    send_cmd(hrrs_pkg::ACT_CLEAR, 64'h1234, 8'h34);
    send_cmd(hrrs_pkg::ACT_LOOKUP, 64'h1234, 8'h00);
    send_cmd(hrrs_pkg::ACT_INSERT, 64'h1234, 8'h07);
    send_cmd(hrrs_pkg::ACT_LOOKUP, 64'hFFFF_FFFF_FFFF_FFFF, 8'h00);
    drain();
  endtask

  task automatic test_copy_limits;
    logic [4:0] settings[4] = '{5'd0, 5'd16, 5'd31, 5'd1};
    send_cmd(hrrs_pkg::ACT_CLEAR, 0, 0);
    for (int i = 0; i < 20; i++) send_cmd(hrrs_pkg::ACT_INSERT, rand_key(), 8'(i));
    drain();
    foreach (settings[s]) begin
      write_copies(settings[s]);
      send_cmd(hrrs_pkg::ACT_LOOKUP, rand_key(), 0);
      send_cmd(hrrs_pkg::ACT_LOOKUP, 64'h0, 0);
      drain();
    end
  endtask

  task automatic random_cmd;
    int r;
    logic [63:0] k;
    logic [7:0] h;
    r = $urandom_range(0, 99);
    k = rand_key();
    h = ($urandom_range(0, 9) < 7) ? 8'($urandom_range(0, 5)) : 8'($urandom_range(0, 255));
    if (ring_tok.size() != 0 && $urandom_range(0, 4) == 0)
      k = ring_tok[$urandom_range(0, ring_tok.size() - 1)] + 64'($urandom_range(0, 1));
    if (r < 48) send_cmd(hrrs_pkg::ACT_INSERT, k, h);
    else if (r < 94) send_cmd(hrrs_pkg::ACT_LOOKUP, k, h);
    else if (r < 97) send_cmd(hrrs_pkg::ACT_CLEAR, k, h);
    else send_cmd(hrrs_pkg::ACT_NONE, k, h);
  endtask

  task automatic test_random;
    logic [4:0] settings[4] = '{5'd2, 5'd7, 5'd16, 5'd3};
    foreach (settings[s]) begin
      write_copies(settings[s]);
      if (s == 3) gaps_on = 0;
      repeat (21) random_cmd();
      drain();
    end
  endtask

  initial begin
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 0;
    @(negedge clk);
    test_directed();
    test_copy_limits();
    test_random();
    if (mismatches == 0 && replicas_due.size() == 0)
      $display("hash_ring_replica_selector_unit verification clean");
    else
      $display("hash_ring_replica_selector_unit verification failed");
    $finish;
  end
endmodule

[sim.f]
hdl/hrrs_pkg.sv
hdl/hrrs_ram.sv
hdl/hash_ring_replica_selector_unit.sv
tb/sv/tb_top.sv
